// ===== design/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman filter: field widths,
// configuration register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Width of sample, estimate and noise registers
  localparam int unsigned DATA_W    = 32;
  // Width of the configuration register index
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

  // Reset value of the process noise register (about 0.01 at 16 fraction bits)
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd655;

  // Signed and unsigned 32-bit saturation limits
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DSTART,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } skf_state_e;

endpackage

// ===== design/skf_intf.sv =====
// ----------------------------------------------------------------------------
// skf_intf
// Valid/ready channel interfaces of the scalar Kalman filter: sample input,
// estimate output and configuration write channel.
// ----------------------------------------------------------------------------
interface skf_in_if;
  import skf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate;

  modport source (output valid, estimate, input ready);
  modport sink   (input valid, estimate, output ready);
endinterface

interface skf_cfg_if;
  import skf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Radix-2 restoring divider for the Kalman gain. Produces
// floor(num * 2^FRAC_BITS / den) one quotient bit per cycle, MSB first,
// for FRAC_BITS+1 quotient bits. A zero divisor yields all-ones.
// ----------------------------------------------------------------------------
module skf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [skf_pkg::DATA_W-1:0]  num_i,
  input  logic [skf_pkg::DATA_W:0]    den_i,
  output logic                        done_o,
  output logic [FRAC_BITS:0]          quot_o
);
  import skf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned REM_W = DATA_W + 2;

  logic [REM_W-1:0]  rem_q;
  logic [DATA_W:0]   den_q;
  logic [FRAC_BITS:0] quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              running_q;
  logic              done_q;

  logic [REM_W-1:0]  den_ext;
  logic              q_bit;
  logic [REM_W-1:0]  rem_nxt;
  logic              last_step;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    den_ext   = {1'b0, den_q};
    q_bit     = (rem_q >= den_ext);
    rem_nxt   = q_bit ? (rem_q - den_ext) : rem_q;
    last_step = (cnt_q == CNT_W'(FRAC_BITS));
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= running_q && last_step;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= '0;
      end else if (running_q) begin
        if (last_step) begin
          running_q <= 1'b0;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Datapath: load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b00, num_i};
      den_q <= den_i;
    end else if (running_q) begin
      rem_q  <= {rem_nxt[REM_W-2:0], 1'b0};
      quot_q <= {quot_q[FRAC_BITS-1:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/skf_mul.sv =====
// ----------------------------------------------------------------------------
// skf_mul
// Dual bit-serial shift-add multiplier. Walks the gain bits LSB first and
// forms floor(gain * diff / 2^FRAC_BITS) and
// floor((1.0 - gain) * p_pred / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module skf_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [FRAC_BITS:0]          gain_i,
  input  logic [skf_pkg::DATA_W:0]    diff_i,
  input  logic [skf_pkg::DATA_W-1:0]  pcov_i,
  output logic                        done_o,
  output logic [skf_pkg::DATA_W+1:0]  corr_o,
  output logic [skf_pkg::DATA_W-1:0]  pnew_o
);
  import skf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned AX_W  = DATA_W + 3;
  localparam int unsigned AP_W  = DATA_W + 2;
  localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]       g_q;
  logic [FRAC_BITS:0]       h_q;
  logic [DATA_W:0]          diff_q;
  logic [DATA_W-1:0]        pcov_q;
  logic signed [AX_W-1:0]   acc_x_q;
  logic [AP_W-1:0]          acc_p_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     running_q;
  logic                     done_q;

  logic signed [AX_W-1:0]   sum_x;
  logic [AP_W-1:0]          sum_p;
  logic                     last_step;

  // Conditional add of each operand under the current multiplier bit
  always_comb begin
    sum_x = acc_x_q +
            (g_q[0] ? $signed({{2{diff_q[DATA_W]}}, diff_q}) : $signed(AX_W'(0)));
    sum_p = acc_p_q + (h_q[0] ? {2'b00, pcov_q} : AP_W'(0));
    last_step = (cnt_q == CNT_W'(FRAC_BITS));
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= running_q && last_step;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= '0;
      end else if (running_q) begin
        if (last_step) begin
          running_q <= 1'b0;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Datapath: accumulate and shift right, no shift on the top bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      g_q     <= gain_i;
      h_q     <= GAIN_ONE - gain_i;
      diff_q  <= diff_i;
      pcov_q  <= pcov_i;
      acc_x_q <= '0;
      acc_p_q <= '0;
    end else if (running_q) begin
      if (last_step) begin
        acc_x_q <= sum_x;
        acc_p_q <= sum_p;
      end else begin
        acc_x_q <= sum_x >>> 1;
        acc_p_q <= sum_p >> 1;
        g_q     <= g_q >> 1;
        h_q     <= h_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign corr_o = acc_x_q[DATA_W+1:0];
  assign pnew_o = acc_p_q[DATA_W-1:0];

endmodule

// ===== design/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Each sample passes through the states PREP (predicted covariance and
// innovation registered), DSTART, DIV (bit-serial gain divider) and MUL
// (bit-serial update multiplier), then DONE loads the output register.
// One sample is taken at a time; a pending estimate may wait in the output
// register while the next sample is taken.
// Reset: estimate 0, covariance 1.0, noise registers to their defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skf_in_if.sink     in_i,
  skf_out_if.source  out_o,
  skf_cfg_if.sink    cfg_i
);
  import skf_pkg::*;

  localparam logic [DATA_W-1:0]  ONE_FX   = DATA_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  skf_state_e        state_q, state_d;

  logic [DATA_W-1:0] proc_noise_q;
  logic [DATA_W-1:0] meas_noise_q;
  logic [DATA_W-1:0] x_q;
  logic [DATA_W-1:0] p_q;
  logic [DATA_W-1:0] z_q;
  logic [DATA_W-1:0] ppred_q;
  logic [DATA_W:0]   diff_q;
  logic [DATA_W-1:0] est_q;
  logic              out_valid_q;

  logic              in_acc;
  logic              cfg_acc;
  logic              in_ready;
  logic              div_start;
  logic              mul_start;
  logic              out_load;
  logic              div_done;
  logic              mul_done;
  logic [DATA_W:0]   ppred_sum;
  logic [DATA_W-1:0] ppred_sat;
  logic [DATA_W:0]   den;
  logic [FRAC_BITS:0] quot;
  logic [FRAC_BITS:0] gain;
  logic [DATA_W+1:0] corr;
  logic [DATA_W-1:0] pnew;
  logic [DATA_W+2:0] xsum;
  logic [DATA_W-1:0] x_new;

  assign in_acc  = in_i.valid && in_ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  // Predict: saturating covariance sum, exact gain denominator
  always_comb begin
    ppred_sum = {1'b0, p_q} + {1'b0, proc_noise_q};
    ppred_sat = ppred_sum[DATA_W] ? U32_MAX : ppred_sum[DATA_W-1:0];
    den       = {1'b0, ppred_q} + {1'b0, meas_noise_q};
  end

  // Clamp the gain to 1.0 (also covers a zero denominator)
  assign gain = (quot > GAIN_ONE) ? GAIN_ONE : quot;

  // Update: add correction and saturate to the signed 32-bit range
  always_comb begin
    xsum = {{3{x_q[DATA_W-1]}}, x_q} + {corr[DATA_W+1], corr};
    if ((xsum[DATA_W+2:DATA_W-1] == 4'b0000) || (xsum[DATA_W+2:DATA_W-1] == 4'b1111)) begin
      x_new = xsum[DATA_W-1:0];
    end else begin
      x_new = xsum[DATA_W+2] ? S32_MIN : S32_MAX;
    end
  end

  skf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_skf_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ppred_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  skf_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_skf_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .gain_i  (gain),
    .diff_i  (diff_q),
    .pcov_i  (ppred_q),
    .done_o  (mul_done),
    .corr_o  (corr),
    .pnew_o  (pnew)
  );

  // Sequencer: next state and strobes
  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= PROCESS_NOISE_RST;
      meas_noise_q <= ONE_FX;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        CFG_PROCESS_NOISE:     proc_noise_q <= cfg_i.data;
        CFG_MEASUREMENT_NOISE: meas_noise_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Filter state: reseed on a start request, commit at the end of a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      p_q <= ONE_FX;
    end else if (in_acc && in_i.start_req) begin
      x_q <= in_i.sample;
      p_q <= ONE_FX;
    end else if (out_load) begin
      x_q <= x_new;
      p_q <= pnew;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      z_q <= in_i.sample;
    end
    if (state_q == ST_PREP) begin
      ppred_q <= ppred_sat;
      diff_q  <= {z_q[DATA_W-1], z_q} - {x_q[DATA_W-1], x_q};
    end
    if (out_load) begin
      est_q <= x_new;
    end
  end

  // Output valid: set on load, clear when the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_i.ready   = in_ready;
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = out_valid_q;
  assign out_o.estimate = est_q;

endmodule

// ===== design/skf_checker.sv =====
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks for the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module skf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [skf_pkg::DATA_W-1:0]  out_estimate_i
);
  import skf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("estimate withdrawn while stalled");

  // Stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_estimate_i))
    else $error("estimate changed while stalled");

  // One sample in flight: no new sample right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("sample taken while another is in flight");

  // A new result frees the input side at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("input not freed when estimate issued");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_estimate_i (out_o.estimate)
);
